/* sv/jfdc_pkg.sv */
// Shared constants for the joystick FIR, dead zone and cubic curve block.
package jfdc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_NULL_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NULL_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE      = 2'd3;

  localparam int CFG_DATA_W  = 24;
  localparam int NULL_W      = 12;
  localparam int DZ_W        = 16;
  localparam int SCALE_W     = 24;
  localparam int OUT_W       = 16;

  // Filter coefficients, unsigned Q0.15 held in 13 bits (each below 0.25)
  localparam int COEF_W      = 13;
  localparam int COEF_IDX_W  = 4;
  localparam int RESET_SAMPLE = 2048;

  // Shared multiplier B operand width (squared deflection term is Q.31)
  localparam int MUL_B_W     = 31;

  typedef logic [COEF_W-1:0] coef_t;

  function automatic coef_t coef_lookup(input logic [COEF_IDX_W-1:0] idx);
    coef_t c;
    case (idx)
      4'd0:    c = 13'd2997;
      4'd1:    c = 13'd5913;
      4'd2:    c = 13'd3005;
      4'd3:    c = 13'd5997;
      4'd4:    c = 13'd4382;
      4'd5:    c = 13'd5997;
      4'd6:    c = 13'd3005;
      4'd7:    c = 13'd5913;
      4'd8:    c = 13'd2997;
      default: c = 13'd0;
    endcase
    return c;
  endfunction

endpackage

/* sv/joystick_fir_deadzone_curve_top.sv */
// Two-axis joystick conditioner: FIR smoothing, dead zone and cubic response curve.
//
// One X/Y sample pair is taken per transfer and produces one curved X/Y result.
// All arithmetic goes through a single registered multiplier under a small
// sequencer, one axis after the other. Each axis runs one multiply-accumulate
// per filter tap, then the dead zone test, deflection scaling and two cube
// multiplies. An axis inside the dead zone ends after the scaling state and a
// saturated axis after the saturation check, both skipping the cube multiplies.
// After the Y axis, the done state waits until the output register is free,
// then returns to idle to accept the next sample pair. in_ready is low while
// an item is in flight; a finished result waits in the output register and
// the next sample pair may be taken meanwhile. Configuration writes take
// effect at once, so make them only while no item is in flight.
module joystick_fir_deadzone_curve_top #(
  parameter int TAPS        = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [SAMPLE_BITS-1:0]                in_x_sample,
  input  logic [SAMPLE_BITS-1:0]                in_y_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [jfdc_pkg::OUT_W-1:0]     out_stick_x,
  output logic signed [jfdc_pkg::OUT_W-1:0]     out_stick_y,
  input  logic                                  cfg_we,
  input  logic [jfdc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [jfdc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int KW = (TAPS > 1) ? $clog2(TAPS) : 1;
  // Filter sum stays below 2^SAMPLE_BITS times the coefficient sum (< 2^16)
  localparam int FW = SAMPLE_BITS + 16;
  localparam int CQW = jfdc_pkg::NULL_W + 15;
  localparam int CW = (FW > CQW) ? FW : CQW;
  localparam int AW = (CW > jfdc_pkg::MUL_B_W) ? CW : jfdc_pkg::MUL_B_W;
  localparam int PW = AW + jfdc_pkg::MUL_B_W;
  localparam int BW = jfdc_pkg::MUL_B_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MAC  = 4'd1;
  localparam logic [3:0] S_FIN  = 4'd2;
  localparam logic [3:0] S_UP   = 4'd3;
  localparam logic [3:0] S_LO   = 4'd4;
  localparam logic [3:0] S_SCL  = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_SQ   = 4'd7;
  localparam logic [3:0] S_CUBE = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]                          state_r, state_nxt;
  logic [KW-1:0]                       k_r, k_nxt;
  logic                                axis_r, axis_nxt;
  logic [SAMPLE_BITS-1:0]              x_hist_r [TAPS];
  logic [SAMPLE_BITS-1:0]              y_hist_r [TAPS];
  logic [jfdc_pkg::NULL_W-1:0]         null_x_r, null_y_r;
  logic [jfdc_pkg::DZ_W-1:0]           dz_r;
  logic [jfdc_pkg::SCALE_W-1:0]        scale_r;
  logic [FW-1:0]                       acc_r, acc_nxt;
  logic [PW-1:0]                       prod_r, prod_nxt;
  logic [AW-1:0]                       mul_a;
  logic [BW-1:0]                       mul_b;
  logic [BW-1:0]                       a_r;
  logic                                up_ok_r, in_dz_r, neg_r;
  logic [CW-1:0]                       m_r;
  logic [jfdc_pkg::OUT_W-1:0]          res_x_r, res_y_r;
  logic                                out_valid_r;
  logic [jfdc_pkg::OUT_W-1:0]          out_x_r, out_y_r;

  logic [SAMPLE_BITS-1:0]              tap_sample;
  logic [jfdc_pkg::NULL_W-1:0]         centre;
  logic [CW-1:0]                       f_ext, cq_ext;
  logic [PW-1:0]                       f2_ext;
  logic                                axis_end;
  logic [jfdc_pkg::OUT_W-1:0]          axis_val;
  logic [jfdc_pkg::OUT_W-1:0]          cube_mag;
  logic                                sat;
  logic                                in_xfer, out_load;

  assign in_ready    = (state_r == S_IDLE);
  assign in_xfer     = in_valid && in_ready;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign out_valid   = out_valid_r;
  assign out_stick_x = out_x_r;
  assign out_stick_y = out_y_r;

  assign tap_sample = axis_r ? y_hist_r[k_r] : x_hist_r[k_r];
  assign centre     = axis_r ? null_y_r : null_x_r;
  assign f_ext      = CW'(acc_r);
  assign cq_ext     = CW'({centre, 15'd0});
  assign f2_ext     = PW'({acc_r, 1'b0});
  assign sat        = |prod_r[PW-1:39];
  assign cube_mag   = {1'b0, prod_r[61:47]};

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MAC: begin
        mul_a = AW'(tap_sample);
        mul_b = BW'(jfdc_pkg::coef_lookup(jfdc_pkg::COEF_IDX_W'(k_r)));
      end
      S_FIN: begin
        mul_a = AW'(17'h10000 + {1'b0, dz_r});
        mul_b = BW'(centre);
      end
      S_UP: begin
        mul_a = AW'(17'h10000 - {1'b0, dz_r});
        mul_b = BW'(centre);
      end
      S_SCL: begin
        mul_a = AW'(m_r);
        mul_b = BW'(scale_r);
      end
      S_CHK: begin
        mul_a = AW'(prod_r[38:8]);
        mul_b = prod_r[38:8];
      end
      S_SQ: begin
        mul_a = AW'(prod_r[61:31]);
        mul_b = a_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = PW'(mul_a) * PW'(mul_b);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    axis_nxt  = axis_r;
    acc_nxt   = acc_r;
    axis_end  = 1'b0;
    axis_val  = '0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_MAC;
          k_nxt     = '0;
          axis_nxt  = 1'b0;
        end
      end
      S_MAC: begin
        // the product is registered, so the previous tap's product is added here
        acc_nxt = (k_r == '0) ? '0 : acc_r + prod_r[FW-1:0];
        if (k_r == KW'(TAPS - 1)) begin
          state_nxt = S_FIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_FIN: begin
        acc_nxt   = acc_r + prod_r[FW-1:0];
        state_nxt = S_UP;
      end
      S_UP:  state_nxt = S_LO;
      S_LO:  state_nxt = S_SCL;
      S_SCL: begin
        if (in_dz_r) begin
          axis_end = 1'b1;
          axis_val = '0;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (sat) begin
          axis_end = 1'b1;
          axis_val = neg_r ? 16'h8000 : 16'h7FFF;
        end else begin
          state_nxt = S_SQ;
        end
      end
      S_SQ:  state_nxt = S_CUBE;
      S_CUBE: begin
        axis_end = 1'b1;
        axis_val = neg_r ? (16'd0 - cube_mag) : cube_mag;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (axis_end) begin
      if (!axis_r) begin
        state_nxt = S_MAC;
        k_nxt     = '0;
        axis_nxt  = 1'b1;
      end else begin
        state_nxt = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
      null_x_r    <= 12'd2048;
      null_y_r    <= 12'd2048;
      dz_r        <= 16'd3277;
      scale_r     <= 24'd6503;
      for (int i = 0; i < TAPS; i++) begin
        x_hist_r[i] <= SAMPLE_BITS'(jfdc_pkg::RESET_SAMPLE);
        y_hist_r[i] <= SAMPLE_BITS'(jfdc_pkg::RESET_SAMPLE);
      end
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      axis_r  <= axis_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          jfdc_pkg::REG_NULL_X:   null_x_r <= cfg_data[jfdc_pkg::NULL_W-1:0];
          jfdc_pkg::REG_NULL_Y:   null_y_r <= cfg_data[jfdc_pkg::NULL_W-1:0];
          jfdc_pkg::REG_DEADZONE: dz_r     <= cfg_data[jfdc_pkg::DZ_W-1:0];
          jfdc_pkg::REG_RANGE:    scale_r  <= cfg_data[jfdc_pkg::SCALE_W-1:0];
          default: ;
        endcase
      end
      // advance the history lines, oldest on tap 0
      if (in_xfer) begin
        for (int i = 0; i < TAPS - 1; i++) begin
          x_hist_r[i] <= x_hist_r[i+1];
          y_hist_r[i] <= y_hist_r[i+1];
        end
        x_hist_r[TAPS-1] <= in_x_sample;
        y_hist_r[TAPS-1] <= in_y_sample;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    if (state_r == S_UP) begin
      up_ok_r <= (f2_ext <= prod_r);
    end
    if (state_r == S_LO) begin
      in_dz_r <= up_ok_r && (f2_ext >= prod_r);
      if (f_ext >= cq_ext) begin
        m_r   <= f_ext - cq_ext;
        neg_r <= 1'b0;
      end else begin
        m_r   <= cq_ext - f_ext;
        neg_r <= 1'b1;
      end
    end
    if (state_r == S_CHK) begin
      a_r <= prod_r[38:8];
    end
    if (axis_end) begin
      if (!axis_r) begin
        res_x_r <= axis_val;
      end else begin
        res_y_r <= axis_val;
      end
    end
    if (out_load) begin
      out_x_r <= res_x_r;
      out_y_r <= res_y_r;
    end
  end

  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (k_r <= KW'(TAPS - 1)))
    else $error("tap counter out of range");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_MAC) && (k_r == '0) && !axis_r)
    else $error("item did not start on X axis tap 0");

  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside of done state");

  a_load_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && out_valid_r && !out_ready |=> (state_r == S_DONE))
    else $error("result overwrote one still waiting");

  a_axis_order: assert property (@(posedge clk) disable iff (!rst_n)
    axis_end && !axis_r |=> (state_r == S_MAC) && axis_r)
    else $error("Y axis did not follow X axis");

endmodule
